/* rtl/ktt_pkg.sv */
// Shared types and constants for the keyed trust table.
// Used by ktt_ctrl, ktt_dp and keyed_trust_table_with_aging_top; no dependencies.
package ktt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 48;

  localparam int ADDR_BITS  = 48;
  localparam int TRUST_BITS = 31;
  localparam int TICK_BITS  = 48;
  localparam int OP_BITS    = 3;
  localparam int ST_BITS    = 3;
  localparam int PCNT_BITS  = 5;

  localparam int IN_TDATA_BITS  = 136;
  localparam int OUT_TDATA_BITS = 88;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LIFETIME = 3'd0;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD           = 3'd0,
    OP_REMOVE        = 3'd1,
    OP_UPDATE        = 3'd2,
    OP_LOOKUP        = 3'd3,
    OP_ADD_OR_UPDATE = 3'd4,
    OP_PURGE         = 3'd5
  } op_t;

  typedef enum logic [ST_BITS-1:0] {
    ST_OK         = 3'd0,
    ST_NEG_TRUST  = 3'd1,
    ST_KEY_EXISTS = 3'd2,
    ST_KEY_ABSENT = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_SCAN  = 2'd2,
    S_EXEC  = 2'd3
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic scan;
    logic exec;
  } ktt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic out_busy;
  } ktt_sts_t;

endpackage

/* rtl/ktt_ctrl.sv */
// Controller state machine of the keyed trust table.
// Depends on ktt_pkg; drives the command struct of ktt_dp.
module ktt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ktt_pkg::ktt_sts_t   sts,
  output ktt_pkg::ktt_cmd_t   cmd
);
  import ktt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_EXEC: begin
        cmd.exec = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/ktt_dp.sv */
// Datapath of the keyed trust table: entry memory, scan counter, match and
// free-slot capture, purge aging check and the result register. Depends on ktt_pkg.
module ktt_dp #(
  parameter int TABLE_DEPTH = ktt_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = ktt_pkg::KEY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ktt_pkg::ktt_cmd_t                   cmd,
  output ktt_pkg::ktt_sts_t                   sts,
  input  logic [ktt_pkg::OP_BITS-1:0]         opcode,
  input  logic [ktt_pkg::ADDR_BITS-1:0]       entry_key,
  input  logic signed [ktt_pkg::TRUST_BITS:0] trust_in,
  input  logic [ktt_pkg::TICK_BITS-1:0]       now_ticks,
  input  logic [ktt_pkg::TICK_BITS-1:0]       lifetime,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ktt_pkg::ST_BITS-1:0]         status,
  output logic [ktt_pkg::TRUST_BITS-1:0]      trust_out,
  output logic [ktt_pkg::TICK_BITS-1:0]       stamp_out,
  output logic [ktt_pkg::PCNT_BITS-1:0]       purged_count
);
  import ktt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = (KEY_BITS < ADDR_BITS) ? KEY_BITS : ADDR_BITS;

  typedef struct packed {
    logic                  vld;
    logic [KW-1:0]         key;
    logic [TRUST_BITS-1:0] trust;
    logic [TICK_BITS-1:0]  stamp;
  } row_t;

  // Request registers.
  op_t                   op_r;
  logic [KW-1:0]         key_r;
  logic [TRUST_BITS-1:0] trust_r;
  logic                  neg_r;
  logic [TICK_BITS-1:0]  now_r;

  // Scan state.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          cnt_end;
  logic [IW-1:0] rd_idx_r;
  logic          rd_vld_r;
  row_t          rd_row_r;
  row_t          mem_r [TABLE_DEPTH];

  logic                  hit_r, free_r;
  logic [IW-1:0]         hit_idx_r, free_idx_r;
  logic [TRUST_BITS-1:0] found_trust_r;
  logic [TICK_BITS-1:0]  found_stamp_r;
  logic [CW-1:0]         pcnt_r;

  // Result register.
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [TRUST_BITS-1:0] out_trust_r;
  logic [TICK_BITS-1:0]  out_stamp_r;
  logic [PCNT_BITS-1:0]  out_pcnt_r;

  logic          expired, purge_hit, key_hit, free_hit;
  logic          mem_we;
  logic [IW-1:0] mem_addr;
  row_t          mem_row;

  logic                  ex_we, ex_vld;
  logic [IW-1:0]         ex_idx;
  status_t               ex_status;
  logic [TRUST_BITS-1:0] ex_trust;
  logic [TICK_BITS-1:0]  ex_stamp;
  logic [PCNT_BITS-1:0]  ex_pcnt;
  logic [CW+PCNT_BITS-1:0] pcnt_wide;

  assign cnt_end = (cnt_r == CW'(TABLE_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = '0;
    end else if ((cmd.clear_wr || cmd.scan) && !cnt_end) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_vld_r <= cmd.scan && !cnt_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(opcode);
      key_r   <= entry_key[KW-1:0];
      trust_r <= trust_in[TRUST_BITS-1:0];
      neg_r   <= trust_in[TRUST_BITS];
      now_r   <= now_ticks;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_row;
    end
    rd_row_r <= mem_r[cnt_r[IW-1:0]];
    rd_idx_r <= cnt_r[IW-1:0];
  end

  // Age beyond lifetime, with a stamp in the future counting as age zero.
  assign expired   = {1'b0, now_r} > ({1'b0, rd_row_r.stamp} + {1'b0, lifetime});
  assign purge_hit = cmd.scan && rd_vld_r && rd_row_r.vld && (op_r == OP_PURGE) && expired;
  assign key_hit   = rd_vld_r && rd_row_r.vld && (rd_row_r.key == key_r);
  assign free_hit  = rd_vld_r && !rd_row_r.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      pcnt_r <= '0;
    end else if (cmd.load) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      pcnt_r <= '0;
    end else if (cmd.scan) begin
      if (key_hit) begin
        hit_r <= 1'b1;
      end
      if (free_hit && !free_r) begin
        free_r <= 1'b1;
      end
      if (purge_hit) begin
        pcnt_r <= pcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && key_hit) begin
      hit_idx_r     <= rd_idx_r;
      found_trust_r <= rd_row_r.trust;
      found_stamp_r <= rd_row_r.stamp;
    end
    if (cmd.scan && free_hit && !free_r) begin
      free_idx_r <= rd_idx_r;
    end
  end

  assign pcnt_wide = {{PCNT_BITS{1'b0}}, pcnt_r};

  // Outcome of the request once the scan is complete.
  always_comb begin
    ex_we     = 1'b0;
    ex_vld    = 1'b1;
    ex_idx    = hit_idx_r;
    ex_status = ST_OK;
    ex_trust  = '0;
    ex_stamp  = '0;
    ex_pcnt   = '0;
    case (op_r)
      OP_ADD: begin
        if (neg_r) begin
          ex_status = ST_NEG_TRUST;
        end else if (hit_r) begin
          ex_status = ST_KEY_EXISTS;
        end else if (!free_r) begin
          ex_status = ST_TABLE_FULL;
        end else begin
          ex_we  = 1'b1;
          ex_idx = free_idx_r;
        end
      end
      OP_REMOVE: begin
        if (!hit_r) begin
          ex_status = ST_KEY_ABSENT;
        end else begin
          ex_we  = 1'b1;
          ex_vld = 1'b0;
        end
      end
      OP_UPDATE: begin
        if (neg_r) begin
          ex_status = ST_NEG_TRUST;
        end else if (!hit_r) begin
          ex_status = ST_KEY_ABSENT;
        end else begin
          ex_we = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (!hit_r) begin
          ex_status = ST_KEY_ABSENT;
        end else begin
          ex_trust = found_trust_r;
          ex_stamp = found_stamp_r;
        end
      end
      OP_ADD_OR_UPDATE: begin
        if (neg_r) begin
          ex_status = ST_NEG_TRUST;
        end else if (hit_r) begin
          ex_we = 1'b1;
        end else if (free_r) begin
          ex_we  = 1'b1;
          ex_idx = free_idx_r;
        end else begin
          ex_status = ST_TABLE_FULL;
        end
      end
      OP_PURGE: begin
        ex_pcnt = pcnt_wide[PCNT_BITS-1:0];
      end
      default: begin
        ex_status = ST_OK;
      end
    endcase
  end

  // Write port: clearing pass, purge invalidation during the scan, or the final write.
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = cnt_r[IW-1:0];
    mem_row  = '0;
    if (cmd.clear_wr && !cnt_end) begin
      mem_we = 1'b1;
    end else if (purge_hit) begin
      mem_we   = 1'b1;
      mem_addr = rd_idx_r;
    end else if (cmd.exec && ex_we) begin
      mem_we        = 1'b1;
      mem_addr      = ex_idx;
      mem_row.vld   = ex_vld;
      mem_row.key   = key_r;
      mem_row.trust = trust_r;
      mem_row.stamp = now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r <= ex_status;
      out_trust_r  <= ex_trust;
      out_stamp_r  <= ex_stamp;
      out_pcnt_r   <= ex_pcnt;
    end
  end

  assign sts.clear_done = cnt_end;
  assign sts.scan_done  = cnt_end && !rd_vld_r;
  assign sts.out_busy   = out_valid_r && !out_tready;

  assign out_tvalid   = out_valid_r;
  assign status       = out_status_r;
  assign trust_out    = out_trust_r;
  assign stamp_out    = out_stamp_r;
  assign purged_count = out_pcnt_r;

endmodule

/* rtl/keyed_trust_table_with_aging_top.sv */
// Top level of the keyed trust table with entry aging: streaming ports,
// lifetime register on the APB-style port, controller and datapath.
// Depends on ktt_pkg, ktt_ctrl and ktt_dp.
//
//  Channel  Direction  Handshake            Contents
//  in_      request    in_tvalid/in_tready  opcode, entry_key, trust_in, now_ticks
//  out_     result     out_tvalid/out_tready status, trust_out, stamp_out, purged_count
//  cfg_     register   psel/penable/pwrite  entry_lifetime at byte address 0
//
// A request is swept through the entry memory via its registered read port in S_SCAN,
// then written back and its result registered in S_EXEC. A new request is taken
// only after the previous one has left S_EXEC. After reset a clearing pass of the
// entry memory holds in_tready low. A request is taken while the
// previous result waits; the block stalls only when a second result is ready
// before the first has been taken.
module keyed_trust_table_with_aging_top #(
  parameter int TABLE_DEPTH = ktt_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = ktt_pkg::KEY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request: [2:0] opcode, [50:3] entry_key, [82:51] trust_in,
  // [130:83] now_ticks, [135:131] zero.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ktt_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  // Result: [2:0] status, [33:3] trust_out, [81:34] stamp_out,
  // [86:82] purged_count, [87] zero.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ktt_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ktt_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [ktt_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [ktt_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                cfg_pready
);
  import ktt_pkg::*;

  ktt_cmd_t cmd;
  ktt_sts_t sts;

  logic [TICK_BITS-1:0]  lifetime_r;
  logic [ST_BITS-1:0]    res_status;
  logic [TRUST_BITS-1:0] res_trust;
  logic [TICK_BITS-1:0]  res_stamp;
  logic [PCNT_BITS-1:0]  res_pcnt;

  // The lifetime register resets to its largest value, so purge removes nothing
  // until software lowers it. Writes to any other address are dropped.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= '1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == REG_LIFETIME)) begin
      lifetime_r <= cfg_pwdata[TICK_BITS-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == REG_LIFETIME) begin
      cfg_prdata = {{(CFG_DATA_BITS-TICK_BITS){1'b0}}, lifetime_r};
    end
  end

  ktt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ktt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (in_tdata[2:0]),
    .entry_key    (in_tdata[50:3]),
    .trust_in     (in_tdata[82:51]),
    .now_ticks    (in_tdata[130:83]),
    .lifetime     (lifetime_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .status       (res_status),
    .trust_out    (res_trust),
    .stamp_out    (res_stamp),
    .purged_count (res_pcnt)
  );

  assign out_tdata = {1'b0, res_pcnt, res_stamp, res_trust, res_status};

`ifndef SYNTH
  // A result is only written into a free or just-drained output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_tvalid && !out_tready))
    else $error("result register overwritten while its result was pending");

  // A result appears only after the controller finished a request.
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.exec))
    else $error("result appeared without a finished request");

  // An accepted request starts the table sweep in the next cycle.
  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> cmd.scan)
    else $error("accepted request did not start a sweep");
`endif

endmodule
